@@ design/dhcp_reply_option_parser_unit_defines.svh @@
// ----------------------------------------------------------------------------
// DHCP reply option parser - assertion macros
// Concurrent check wrappers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef DHCP_REPLY_OPTION_PARSER_UNIT_DEFINES_SVH
`define DHCP_REPLY_OPTION_PARSER_UNIT_DEFINES_SVH

`ifndef SYNTH

// same-cycle implication
`define DRP_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DRP_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define DRP_ASSERT_NOW(label, clk, rstn, ante, cons, msg)
`define DRP_ASSERT_NEXT(label, clk, rstn, ante, cons, msg)

`endif

`endif

@@ design/dhcprp_pkg.sv @@
// ----------------------------------------------------------------------------
// DHCP reply option parser - shared package
// Field ids, walk phases, reply kinds, protocol constants, capture control.
// ----------------------------------------------------------------------------
package dhcprp_pkg;

    localparam int NUM_FIELDS = 6;
    localparam int CAP_DEPTH  = 4;   // option value bytes taken per capture
    localparam int APB_ADDR_W = 3;

    localparam logic REG_XID_IDX = 1'b0;

    localparam int MIN_FRAME_LEN  = 70;
    localparam int XID_OFFSET     = 4;
    localparam int YIADDR_OFFSET  = 16;
    localparam int OPTIONS_OFFSET = 240;
    localparam int MSG_TYPE_SKIP  = 2;

    localparam logic [7:0] OPT_MASK       = 8'd1;
    localparam logic [7:0] OPT_ROUTER     = 8'd3;
    localparam logic [7:0] OPT_DNS        = 8'd6;
    localparam logic [7:0] OPT_LEASE      = 8'd51;
    localparam logic [7:0] OPT_MSG_TYPE   = 8'd53;
    localparam logic [7:0] OPT_SERVER     = 8'd54;
    localparam logic [7:0] SERVER_PORT_LO = 8'd67;
    localparam logic [7:0] OP_BOOTREPLY   = 8'd2;
    localparam logic [7:0] DHCPOFFER      = 8'h02;
    localparam logic [7:0] DHCPACK        = 8'h05;

    localparam logic [31:0] MS_PER_S = 32'd1000;

    typedef logic [NUM_FIELDS-1:0][31:0] field_set_t;

    typedef enum logic [2:0] {
        FLD_YIADDR = 3'd0,
        FLD_MASK   = 3'd1,
        FLD_ROUTER = 3'd2,
        FLD_DNS    = 3'd3,
        FLD_SERVER = 3'd4,
        FLD_LEASE  = 3'd5,
        FLD_NONE   = 3'd6
    } field_id_t;

    typedef enum logic [1:0] {
        PH_CODE = 2'd0,
        PH_LEN  = 2'd1,
        PH_SKIP = 2'd2
    } opt_phase_t;

    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_OFFER = 2'd1,
        KIND_ACK   = 2'd2
    } reply_kind_t;

    // per-word control from the walker to the capture unit
    typedef struct packed {
        logic      step;        // word lands inside the frame window
        logic      yi_shift;    // word is a yiaddr byte
        field_id_t open_field;  // capture opened by this length byte
        logic      finish;      // last word of the frame
        field_id_t tail_field;  // capture opened by a trailing option code
        logic      commit;      // valid offer: shadow -> committed
    } cap_ctrl_t;

    function automatic field_id_t field_for(input logic [7:0] code);
        field_id_t f;
        unique case (code)
            OPT_MASK:   f = FLD_MASK;
            OPT_ROUTER: f = FLD_ROUTER;
            OPT_DNS:    f = FLD_DNS;
            OPT_SERVER: f = FLD_SERVER;
            OPT_LEASE:  f = FLD_LEASE;
            default:    f = FLD_NONE;
        endcase
        return f;
    endfunction

endpackage

@@ design/dhcprp_capture.sv @@
// ----------------------------------------------------------------------------
// DHCP reply option parser - capture unit
// Four-deep delay line of open captures, shadow and committed field banks.
// ----------------------------------------------------------------------------
module dhcprp_capture (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  dhcprp_pkg::cap_ctrl_t  ctrl,
    input  logic [7:0]             data_byte,
    output dhcprp_pkg::field_set_t committed
);
    import dhcprp_pkg::*;

    // line_reg[i]: capture that completes after i+1 more bytes
    field_id_t  line_reg  [CAP_DEPTH];
    field_id_t  line_next [CAP_DEPTH];
    logic [31:0] recent_reg, recent_next;
    field_set_t shadow_reg, shadow_next;
    field_set_t committed_reg, committed_next;

    field_set_t  shadow_work;
    logic        lease_hit;
    logic [31:0] lease_raw;
    logic [31:0] cap_val;
    field_id_t   sel;

    always_comb begin
        recent_next    = recent_reg;
        line_next      = line_reg;
        shadow_work    = shadow_reg;
        committed_next = committed_reg;
        lease_hit      = 1'b0;
        lease_raw      = '0;
        cap_val        = '0;
        sel            = FLD_NONE;

        if (ctrl.step) begin
            recent_next = {recent_reg[23:0], data_byte};
            sel = line_reg[0];
            if (sel == FLD_LEASE) begin
                lease_hit = 1'b1;
                lease_raw = recent_next;
            end else if (sel != FLD_NONE) begin
                shadow_work[sel] = recent_next;
            end
            for (int i = 0; i < CAP_DEPTH - 1; i++) begin
                line_next[i] = line_reg[i+1];
            end
            line_next[CAP_DEPTH-1] = ctrl.open_field;
            if (ctrl.yi_shift) begin
                shadow_work[FLD_YIADDR] = {shadow_reg[FLD_YIADDR][23:0], data_byte};
            end
        end

        if (ctrl.finish) begin
            if (ctrl.tail_field != FLD_NONE) begin
                line_next[CAP_DEPTH-1] = ctrl.tail_field;
            end
            // missing bytes read as zero; older captures first
            for (int r = 0; r < CAP_DEPTH; r++) begin
                sel = line_next[r];
                if (r == CAP_DEPTH - 1) begin
                    cap_val = '0;
                end else begin
                    cap_val = recent_next << (8 * (r + 1));
                end
                if (sel == FLD_LEASE) begin
                    lease_hit = 1'b1;
                    lease_raw = cap_val;
                end else if (sel != FLD_NONE) begin
                    shadow_work[sel] = cap_val;
                end
            end
        end

        if (lease_hit) begin
            shadow_work[FLD_LEASE] = lease_raw * MS_PER_S;
        end

        if (ctrl.finish) begin
            if (ctrl.commit) begin
                committed_next = shadow_work;
            end
            shadow_next = committed_next;
            recent_next = '0;
            for (int i = 0; i < CAP_DEPTH; i++) begin
                line_next[i] = FLD_NONE;
            end
        end else begin
            shadow_next = shadow_work;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            recent_reg    <= '0;
            shadow_reg    <= '0;
            committed_reg <= '0;
            for (int i = 0; i < CAP_DEPTH; i++) begin
                line_reg[i] <= FLD_NONE;
            end
        end else begin
            recent_reg    <= recent_next;
            shadow_reg    <= shadow_next;
            committed_reg <= committed_next;
            line_reg      <= line_next;
        end
    end

    assign committed = committed_reg;

endmodule

@@ design/dhcp_reply_option_parser_unit.sv @@
// ----------------------------------------------------------------------------
// DHCP reply option parser - top level
// Byte-wide frame parser that reports DHCP offers and acks for this client.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one frame byte per word (s_rx_byte) with s_last_byte on the
//   final byte. m_ channel: one result word per frame, issued for the last
//   byte: reply kind plus the six held fields (offer address, mask, router,
//   DNS, server id, lease in ms).
//   APB: transaction id at byte address 0; pready is always high.
//   Throughput: one byte per clock unless a last byte waits on a pending
//   result. The input register feeds the parse/capture logic, which
//   updates state in that same cycle and, for a last byte, sets m_valid.
//   Stall: while a result waits on m_ready, non-last bytes of the next frame
//   keep flowing; a following last byte waits in the input register and
//   s_ready drops only then.
//   Reset: all held fields, the transaction id and frame state clear to zero;
//   no clearing pass, the block takes words right after reset.
// ----------------------------------------------------------------------------
`include "dhcp_reply_option_parser_unit_defines.svh"

module dhcp_reply_option_parser_unit #(
    parameter int PAYLOAD_OFFSET      = 42,
    parameter int SRC_PORT_LOW_OFFSET = 35,
    parameter int MAX_FRAME_BYTES     = 2048
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // config
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [dhcprp_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    // frame bytes in
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [7:0]                        s_rx_byte,
    input  logic                              s_last_byte,
    // results out
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [1:0]                        m_reply_kind,
    output logic [31:0]                       m_offered_ip,
    output logic [31:0]                       m_subnet_mask,
    output logic [31:0]                       m_gateway_ip,
    output logic [31:0]                       m_dns_ip,
    output logic [31:0]                       m_server_ip,
    output logic [31:0]                       m_lease_ms
);
    import dhcprp_pkg::*;

    // position counter saturates at MAX_FRAME_BYTES, so it must hold that value
    localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);

    localparam logic [POS_W-1:0] POS_MAX  = POS_W'(MAX_FRAME_BYTES);
    localparam logic [POS_W-1:0] POS_SRC  = POS_W'(SRC_PORT_LOW_OFFSET);
    localparam logic [POS_W-1:0] POS_OP   = POS_W'(PAYLOAD_OFFSET);
    localparam logic [POS_W-1:0] POS_XID0 = POS_W'(PAYLOAD_OFFSET + XID_OFFSET);
    localparam logic [POS_W-1:0] POS_XID3 = POS_W'(PAYLOAD_OFFSET + XID_OFFSET + 3);
    localparam logic [POS_W-1:0] POS_YI0  = POS_W'(PAYLOAD_OFFSET + YIADDR_OFFSET);
    localparam logic [POS_W-1:0] POS_YI3  = POS_W'(PAYLOAD_OFFSET + YIADDR_OFFSET + 3);
    localparam logic [POS_W-1:0] POS_WALK = POS_W'(PAYLOAD_OFFSET + OPTIONS_OFFSET);
    localparam logic [POS_W-1:0] POS_MSG  =
        POS_W'(PAYLOAD_OFFSET + OPTIONS_OFFSET + MSG_TYPE_SKIP);
    localparam logic [POS_W-1:0] POS_MIN  = POS_W'(MIN_FRAME_LEN);

    // header check bits
    localparam int CHK_PORT = 0;
    localparam int CHK_OP   = 1;
    localparam int CHK_XID  = 2;
    localparam int CHK_MSG  = 3;

    // ---------------- configuration ----------------
    logic [31:0] xid_reg;

    assign pready = 1'b1;
    assign prdata = (paddr[APB_ADDR_W-1] == REG_XID_IDX) ? xid_reg : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            xid_reg <= '0;
        end else if (psel && penable && pwrite && pready &&
                     (paddr[APB_ADDR_W-1] == REG_XID_IDX)) begin
            xid_reg <= pwdata;
        end
    end

    // ---------------- input register ----------------
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       adv;   // input word moves into the parse stage this cycle

    // a last word needs the result register; other words always move on
    assign adv     = in_valid_reg && (!in_last_reg || !m_valid || m_ready);
    assign s_ready = !in_valid_reg || adv;

    always_comb begin
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (adv) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_rx_byte;
            in_last_reg <= s_last_byte;
        end
    end

    // ---------------- header checks and option walk ----------------
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [3:0]       chk_reg, chk_next;
    logic [7:0]       msg_reg, msg_next;
    opt_phase_t       phase_reg, phase_next;
    logic [7:0]       cur_opt_reg, cur_opt_next;
    logic [7:0]       left_reg, left_next;

    logic        in_window;
    logic [1:0]  xid_k;
    logic [7:0]  xid_want;
    logic        reply_ok;
    cap_ctrl_t   cap_ctrl;
    reply_kind_t kind_reg, kind_next;
    logic        m_valid_reg, m_valid_next;

    assign in_window = (pos_reg < POS_MAX);
    assign xid_k     = 2'(pos_reg - POS_XID0);
    assign xid_want  = 8'(xid_reg >> {xid_k, 3'b000});

    always_comb begin
        pos_next     = pos_reg;
        chk_next     = chk_reg;
        msg_next     = msg_reg;
        phase_next   = phase_reg;
        cur_opt_next = cur_opt_reg;
        left_next    = left_reg;
        reply_ok     = 1'b0;
        kind_next    = kind_reg;

        cap_ctrl            = '0;
        cap_ctrl.open_field = FLD_NONE;
        cap_ctrl.tail_field = FLD_NONE;

        if (adv && in_window) begin
            cap_ctrl.step     = 1'b1;
            cap_ctrl.yi_shift = (pos_reg >= POS_YI0) && (pos_reg <= POS_YI3);
            pos_next          = pos_reg + 1'b1;

            if (pos_reg == POS_SRC && in_byte_reg == SERVER_PORT_LO) begin
                chk_next[CHK_PORT] = 1'b1;
            end
            if (pos_reg == POS_OP && in_byte_reg == OP_BOOTREPLY) begin
                chk_next[CHK_OP] = 1'b1;
            end
            // first xid byte arms the check, any later mismatch drops it
            if (pos_reg >= POS_XID0 && pos_reg <= POS_XID3) begin
                if (xid_k == 2'd0 && in_byte_reg == xid_want) begin
                    chk_next[CHK_XID] = 1'b1;
                end else if (in_byte_reg != xid_want) begin
                    chk_next[CHK_XID] = 1'b0;
                end
            end
            if (pos_reg == POS_WALK && in_byte_reg == OPT_MSG_TYPE) begin
                chk_next[CHK_MSG] = 1'b1;
            end
            if (pos_reg == POS_MSG) begin
                msg_next = in_byte_reg;
            end

            // options walk as code/length pairs, pad and end included
            if (pos_reg >= POS_WALK) begin
                unique case (phase_reg)
                    PH_CODE: begin
                        cur_opt_next = in_byte_reg;
                        phase_next   = PH_LEN;
                    end
                    PH_LEN: begin
                        left_next           = in_byte_reg;
                        cap_ctrl.open_field = field_for(cur_opt_reg);
                        phase_next = (in_byte_reg != 8'd0) ? PH_SKIP : PH_CODE;
                    end
                    PH_SKIP: begin
                        left_next = left_reg - 1'b1;
                        if (left_reg == 8'd1) begin
                            phase_next = PH_CODE;
                        end
                    end
                    default: begin
                        phase_next = PH_CODE;
                    end
                endcase
            end
        end

        if (adv && in_last_reg) begin
            cap_ctrl.finish = 1'b1;
            // a code as the final byte: length zero, value zero
            if (pos_next > POS_WALK && phase_next == PH_LEN) begin
                cap_ctrl.tail_field = field_for(cur_opt_next);
            end
            reply_ok = (pos_next >= POS_MIN) && (chk_next == 4'hF);
            if (reply_ok && msg_next == DHCPOFFER) begin
                cap_ctrl.commit = 1'b1;
                kind_next       = KIND_OFFER;
            end else if (reply_ok && msg_next == DHCPACK) begin
                kind_next = KIND_ACK;
            end else begin
                kind_next = KIND_NONE;
            end
            // clear frame state for the next frame
            pos_next     = '0;
            chk_next     = '0;
            msg_next     = '0;
            phase_next   = PH_CODE;
            cur_opt_next = '0;
            left_next    = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            chk_reg     <= '0;
            msg_reg     <= '0;
            phase_reg   <= PH_CODE;
            cur_opt_reg <= '0;
            left_reg    <= '0;
        end else begin
            pos_reg     <= pos_next;
            chk_reg     <= chk_next;
            msg_reg     <= msg_next;
            phase_reg   <= phase_next;
            cur_opt_reg <= cur_opt_next;
            left_reg    <= left_next;
        end
    end

    // ---------------- captures and held fields ----------------
    field_set_t committed;

    dhcprp_capture u_capture (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (cap_ctrl),
        .data_byte (in_byte_reg),
        .committed (committed)
    );

    // ---------------- result register ----------------
    // held fields only change on a last word, which waits for a free slot,
    // so they are read straight from the committed bank
    always_comb begin
        if (adv && in_last_reg) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            kind_reg    <= KIND_NONE;
        end else begin
            m_valid_reg <= m_valid_next;
            kind_reg    <= kind_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_reply_kind  = kind_reg;
    assign m_offered_ip  = committed[FLD_YIADDR];
    assign m_subnet_mask = committed[FLD_MASK];
    assign m_gateway_ip  = committed[FLD_ROUTER];
    assign m_dns_ip      = committed[FLD_DNS];
    assign m_server_ip   = committed[FLD_SERVER];
    assign m_lease_ms    = committed[FLD_LEASE];

    // ---------------- checks ----------------
    `DRP_ASSERT_NEXT(a_held_stable, aclk, aresetn, !(adv && in_last_reg), $stable(m_offered_ip) && $stable(m_lease_ms) && $stable(m_server_ip), "held fields changed without a frame end")
    `DRP_ASSERT_NEXT(a_frame_restart, aclk, aresetn, adv && in_last_reg, pos_reg == '0 && phase_reg == PH_CODE && chk_reg == '0, "frame state not cleared after last word")
    `DRP_ASSERT_NOW(a_result_source, aclk, aresetn, $rose(m_valid_reg), $past(adv && in_last_reg), "result raised without a last word")
    `DRP_ASSERT_NOW(a_no_overrun, aclk, aresetn, m_valid_reg && !m_ready && in_valid_reg && in_last_reg, !s_ready, "last word accepted over a pending result")

endmodule
